>>> rtl/dcdm_pkg.sv
package dcdm_pkg;

	// ASCII codes of interest
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_NINE = 8'h39;
	localparam logic [7:0] ASCII_LF   = 8'h0A;
	localparam logic [7:0] ASCII_CR   = 8'h0D;

	// Command layout
	localparam int DIGIT_COUNT = 10;
	localparam int CMP_W       = 14;
	localparam int CMP_COUNT   = 8;
	localparam int FIFO_DEPTH_DEF = 2;

	// Gear and direction codes
	localparam logic [3:0] GEAR_REV  = 4'd0;
	localparam logic [3:0] GEAR_FWD  = 4'd1;
	localparam logic [3:0] DIR_RIGHT = 4'd2;
	localparam logic [3:0] DIR_LEFT  = 4'd3;

	// One complete ten-digit command, most significant digit at index 3
	typedef struct packed {
		logic [3:0]      gear;
		logic [3:0][3:0] spd_d;
		logic [3:0]      dir;
		logic [3:0][3:0] trn_d;
	} cmd_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Four decimal digits to a binary value, at most 9999
	function automatic logic [CMP_W-1:0] four_dig(input logic [3:0][3:0] d);
		logic [CMP_W-1:0] acc;
		acc = CMP_W'(d[3]) * CMP_W'(1000) + CMP_W'(d[2]) * CMP_W'(100)
			+ CMP_W'(d[1]) * CMP_W'(10) + CMP_W'(d[0]);
		return acc;
	endfunction

endpackage

>>> rtl/digit_command_drive_mixer.sv
// Channel  Signals                      Beat
// s        s_tvalid s_tready s_tdata    one received byte
// m        m_tvalid m_tready m_tdata    eight compares after a ten-digit command
//          m_tuser                      compares were rewritten
//
// One byte is taken every cycle while the command queue has room.
// A terminator after ten digits writes the command into the queue; stage 1 then converts
// the digits, and loading the compares raises m_tvalid, unless the back end is stalled.
// Reset clears the digit count, the queue, the pipeline and all compares to zero.
// A stalled result stalls the back end only; bytes keep flowing until the queue fills.
module digit_command_drive_mixer import dcdm_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF   // command queue depth, 2 or more
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // [7:0] rx_byte
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// [13:0] tim_a_ch1, [27:14] tim_a_ch2, [41:28] tim_a_ch3, [55:42] tim_a_ch4,
	// [69:56] tim_b_ch1, [83:70] tim_b_ch2, [97:84] tim_b_ch3, [111:98] tim_b_ch4
	output logic [CMP_COUNT*CMP_W-1:0] m_tdata,
	output logic                       m_tuser    // [0] drive_applied
);

	q_stat_t q_stat;
	logic    push;
	cmd_t    push_cmd;
	logic    pop;
	cmd_t    pop_cmd;

	dcdm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	dcdm_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.q_stat   (q_stat)
	);

	dcdm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.pop_cmd  (pop_cmd),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

>>> rtl/dcdm_front.sv
module dcdm_front import dcdm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	input  q_stat_t    q_stat,
	output logic       push,
	output cmd_t       push_cmd
);

	logic [3:0] dig_q [DIGIT_COUNT];
	logic [3:0] count_q;
	logic       accept;
	logic       is_digit;
	logic       is_term;
	logic       have_room;
	logic       count_full;

	// Classify the incoming beat
	assign s_tready   = !q_stat.full;
	assign accept     = s_tvalid && s_tready;
	assign is_digit   = (s_tdata >= ASCII_ZERO) && (s_tdata <= ASCII_NINE);
	assign is_term    = (s_tdata == ASCII_LF) || (s_tdata == ASCII_CR);
	assign count_full = (count_q == 4'(DIGIT_COUNT));
	assign have_room  = (count_q < 4'(DIGIT_COUNT));
	assign push       = accept && is_term && count_full;

	// Store digits while room is left
	always_ff @(posedge clk) begin
		if (accept && is_digit && have_room) begin
			dig_q[count_q] <= 4'(s_tdata - ASCII_ZERO);
		end
	end

	// Count digits, clear on every terminator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (is_term) begin
				count_q <= '0;
			end else if (is_digit && have_room) begin
				count_q <= count_q + 4'd1;
			end
		end
	end

	// Gather the command fields
	assign push_cmd.gear     = dig_q[0];
	assign push_cmd.spd_d[3] = dig_q[1];
	assign push_cmd.spd_d[2] = dig_q[2];
	assign push_cmd.spd_d[1] = dig_q[3];
	assign push_cmd.spd_d[0] = dig_q[4];
	assign push_cmd.dir      = dig_q[5];
	assign push_cmd.trn_d[3] = dig_q[6];
	assign push_cmd.trn_d[2] = dig_q[7];
	assign push_cmd.trn_d[1] = dig_q[8];
	assign push_cmd.trn_d[0] = dig_q[9];

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 4'(DIGIT_COUNT)) else $error("digit count past ten");
	a_push_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> count_q == 4'd0) else $error("count not cleared after command");
`endif

endmodule

>>> rtl/dcdm_fifo.sv
module dcdm_fifo import dcdm_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output cmd_t    pop_cmd,
	output q_stat_t q_stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign q_stat.full  = (fill_q == CNT_W'(DEPTH));
	assign q_stat.empty = (fill_q == '0);
	assign do_push = push && !q_stat.full;
	assign do_pop  = pop && !q_stat.empty;
	assign pop_cmd = mem_q[rd_ptr_q];

	// Write entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/dcdm_back.sv
module dcdm_back import dcdm_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  q_stat_t                    q_stat,
	input  cmd_t                       pop_cmd,
	output logic                       pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [CMP_COUNT*CMP_W-1:0] m_tdata,
	output logic                       m_tuser
);

	// Compare slots in output order
	localparam int CH_A1 = 0;
	localparam int CH_A2 = 1;
	localparam int CH_A3 = 2;
	localparam int CH_A4 = 3;
	localparam int CH_B1 = 4;
	localparam int CH_B2 = 5;
	localparam int CH_B3 = 6;
	localparam int CH_B4 = 7;

	logic             vld_s1;
	logic [3:0]       gear_s1;
	logic [3:0]       dir_s1;
	logic [CMP_W-1:0] speed_s1;
	logic [CMP_W-1:0] turn_s1;
	logic             adv;
	logic [CMP_W-1:0] cmp_q [CMP_COUNT];
	logic [CMP_W-1:0] cmp_nxt [CMP_COUNT];
	logic             out_vld_q;
	logic             applied_q;
	logic [CMP_W-1:0] turn_c;
	logic [CMP_W-1:0] diff;
	logic [CMP_W-1:0] right_v;
	logic [CMP_W-1:0] left_v;
	logic             cmd_ok;
	logic             fwd;

	// Pipeline control
	assign adv = vld_s1 && (!out_vld_q || m_tready);
	assign pop = !q_stat.empty && (!vld_s1 || adv);

	// Stage 1: convert digits to speed and turn
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (pop) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			gear_s1  <= pop_cmd.gear;
			dir_s1   <= pop_cmd.dir;
			speed_s1 <= four_dig(pop_cmd.spd_d);
			turn_s1  <= four_dig(pop_cmd.trn_d);
		end
	end

	// Stage 2: clamp turn and mix both sides
	always_comb begin
		turn_c  = (turn_s1 > speed_s1) ? speed_s1 : turn_s1;
		diff    = speed_s1 - turn_c;
		cmd_ok  = ((gear_s1 == GEAR_REV) || (gear_s1 == GEAR_FWD))
			&& ((dir_s1 == DIR_RIGHT) || (dir_s1 == DIR_LEFT));
		fwd     = (gear_s1 == GEAR_FWD);
		right_v = (dir_s1 == DIR_LEFT) ? speed_s1 : diff;
		left_v  = (dir_s1 == DIR_LEFT) ? diff : speed_s1;
		for (int k = 0; k < CMP_COUNT; k++) begin
			cmp_nxt[k] = cmp_q[k];
		end
		if (cmd_ok) begin
			cmp_nxt[CH_A1] = fwd ? right_v : '0;
			cmp_nxt[CH_B1] = fwd ? right_v : '0;
			cmp_nxt[CH_A2] = fwd ? '0 : right_v;
			cmp_nxt[CH_B2] = fwd ? '0 : right_v;
			cmp_nxt[CH_A3] = fwd ? left_v : '0;
			cmp_nxt[CH_B4] = fwd ? left_v : '0;
			cmp_nxt[CH_A4] = fwd ? '0 : left_v;
			cmp_nxt[CH_B3] = fwd ? '0 : left_v;
		end
	end

	// Hold compares and the output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CMP_COUNT; k++) begin
				cmp_q[k] <= '0;
			end
			out_vld_q <= 1'b0;
			applied_q <= 1'b0;
		end else begin
			if (adv) begin
				for (int k = 0; k < CMP_COUNT; k++) begin
					cmp_q[k] <= cmp_nxt[k];
				end
				applied_q <= cmd_ok;
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = applied_q;
	always_comb begin
		for (int k = 0; k < CMP_COUNT; k++) begin
			m_tdata[k*CMP_W +: CMP_W] = cmp_q[k];
		end
	end

`ifndef SYNTHESIS
	a_pairs_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_q[CH_A1] == cmp_q[CH_B1] && cmp_q[CH_A2] == cmp_q[CH_B2]
		&& cmp_q[CH_A3] == cmp_q[CH_B4] && cmp_q[CH_A4] == cmp_q[CH_B3])
		else $error("timer A and B compares disagree");
	a_one_gear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmp_q[CH_A1] == '0 && cmp_q[CH_A3] == '0)
		|| (cmp_q[CH_A2] == '0 && cmp_q[CH_A4] == '0))
		else $error("forward and reverse driven together");
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("compares changed under a stalled beat");
`endif

endmodule
